// File: rtl/bre_pkg.sv
// bre_pkg: shared types, constants and the combine function for the boolean rpn evaluator
// no dependencies; compiled first
package bre_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// token function codes
	typedef enum logic [2:0] {
		FN_PUSH  = 3'd0,
		FN_NOT   = 3'd1,
		FN_AND   = 3'd2,
		FN_OR    = 3'd3,
		FN_XOR   = 3'd4,
		FN_NAND  = 3'd5,
		FN_NOR   = 3'd6,
		FN_EQUAL = 3'd7
	} func_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_UNDERFLOW   = 2'd1,
		ERR_FINAL_DEPTH = 2'd2,
		ERR_OVERFLOW    = 2'd3
	} err_t;

	// command from the token decoder to the stack
	typedef struct packed {
		logic  push;
		logic  invert;
		logic  combine;
		logic  clear;
		func_t func;
		logic  din;
	} stk_cmd_t;

	// stack status back to the decoder
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [DEPTH_W-1:0] depth_nxt;
		logic               top_nxt;
	} stk_stat_t;

	// two-operand operators, lhs is the entry below the top
	function automatic logic combine_bits(func_t f, logic lhs, logic rhs);
		logic r;
		case (f)
			FN_AND:  r = lhs & rhs;
			FN_OR:   r = lhs | rhs;
			FN_XOR:  r = lhs ^ rhs;
			FN_NAND: r = ~(lhs & rhs);
			FN_NOR:  r = ~(lhs | rhs);
			default: r = ~(lhs ^ rhs);
		endcase
		return r;
	endfunction

endpackage

// File: rtl/bre_if.sv
// bre_tok_if and bre_res_if: valid/ready channels for tokens and results
// no dependencies
interface bre_tok_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic       operand_bit;
	logic       last;

	modport source (output valid, output func, output operand_bit, output last, input ready);
	modport sink   (input valid, input func, input operand_bit, input last, output ready);
endinterface

interface bre_res_if;
	logic       valid;
	logic       ready;
	logic       result_bit;
	logic [1:0] error_code;

	modport source (output valid, output result_bit, output error_code, input ready);
	modport sink   (input valid, input result_bit, input error_code, output ready);
endinterface

// File: rtl/bre_stack.sv
// bre_stack: bit stack with the top three entries in registers and the rest in a memory
// depends on bre_pkg
module bre_stack
	import bre_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  stk_cmd_t  cmd,
	output stk_stat_t stat
);

	logic                mem [STACK_DEPTH];
	logic [DEPTH_W-1:0]  depth_q;
	logic [DEPTH_W-1:0]  depth_d;
	logic                top_q, nxt_q, thd_q, rd_q, thd_mem_q;
	logic                top_d, nxt_d, thd;
	logic                wr_en, rd_en;
	logic [DEPTH_W-1:0]  wr_pos, rd_pos;

	// third entry comes from the memory read register after a pop
	assign thd = thd_mem_q ? rd_q : thd_q;

	// next stack state and memory access for this word
	always_comb begin
		depth_d = depth_q;
		top_d   = top_q;
		nxt_d   = nxt_q;
		wr_en   = 1'b0;
		wr_pos  = depth_q;
		rd_en   = 1'b0;
		rd_pos  = depth_q - DEPTH_W'(4);
		if (cmd.push) begin
			depth_d = depth_q + DEPTH_W'(1);
			top_d   = cmd.din;
			nxt_d   = top_q;
			wr_en   = 1'b1;
		end else if (cmd.invert) begin
			top_d  = ~top_q;
			wr_en  = 1'b1;
			wr_pos = depth_q - DEPTH_W'(1);
		end else if (cmd.combine) begin
			depth_d = depth_q - DEPTH_W'(1);
			top_d   = combine_bits(cmd.func, nxt_q, top_q);
			nxt_d   = thd;
			wr_en   = 1'b1;
			wr_pos  = depth_q - DEPTH_W'(2);
			rd_en   = (depth_q >= DEPTH_W'(4));
		end
	end

	assign stat.depth     = depth_q;
	assign stat.depth_nxt = depth_d;
	assign stat.top_nxt   = top_d;

	// stack memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_pos[ADDR_W-1:0]] <= top_d;
		end
		if (rd_en) begin
			rd_q <= mem[rd_pos[ADDR_W-1:0]];
		end
	end

	// top entries
	always_ff @(posedge clk) begin
		top_q <= top_d;
		nxt_q <= nxt_d;
		if (cmd.push) begin
			thd_q <= nxt_q;
		end
	end

	// depth and third-entry source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			thd_mem_q <= 1'b0;
		end else begin
			depth_q <= cmd.clear ? '0 : depth_d;
			if (cmd.push) begin
				thd_mem_q <= 1'b0;
			end else if (cmd.combine) begin
				thd_mem_q <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/boolean_rpn_evaluator.sv
// boolean_rpn_evaluator: top level, token decode, sticky error and result register
// depends on bre_pkg, bre_if, bre_stack
//
//   channel | dir | fields                       | word
//   tok     | in  | func, operand_bit, last      | one token
//   res     | out | result_bit, error_code       | one result per last token
//
// one token per cycle while tok.ready is high; each token works on the register-held top of the stack
// a result is registered in the cycle after its last token is accepted and sits in an output register
// tok.ready drops only while that register is full and res.ready is low
// reset clears depth, error and output valid; no memory clearing pass is needed
module boolean_rpn_evaluator
	import bre_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	bre_tok_if.sink   tok,
	bre_res_if.source res
);

	stk_cmd_t  cmd;
	stk_stat_t stat;
	func_t     func;
	logic      accept;
	logic      op_ok;
	err_t      err_op, err_cur, err_fin;
	err_t      sticky_q, error_code_q;
	logic      out_valid_q, result_bit_q;

	assign func   = func_t'(tok.func);
	assign tok.ready = !out_valid_q || res.ready;
	assign accept = tok.valid && tok.ready;

	// decode token against current depth
	always_comb begin
		cmd        = '0;
		cmd.func   = func;
		cmd.din    = tok.operand_bit;
		cmd.clear  = accept && tok.last;
		op_ok      = 1'b1;
		err_op     = ERR_NONE;
		unique case (func)
			FN_PUSH: begin
				op_ok    = (stat.depth < DEPTH_W'(STACK_DEPTH));
				cmd.push = accept && op_ok;
				err_op   = ERR_OVERFLOW;
			end
			FN_NOT: begin
				op_ok      = (stat.depth >= DEPTH_W'(1));
				cmd.invert = accept && op_ok;
				err_op     = ERR_UNDERFLOW;
			end
			default: begin
				op_ok       = (stat.depth >= DEPTH_W'(2));
				cmd.combine = accept && op_ok;
				err_op      = ERR_UNDERFLOW;
			end
		endcase
	end

	// first error wins, final depth check on the last token
	always_comb begin
		err_cur = sticky_q;
		if (sticky_q == ERR_NONE && !op_ok) begin
			err_cur = err_op;
		end
		err_fin = err_cur;
		if (err_cur == ERR_NONE && stat.depth_nxt != DEPTH_W'(1)) begin
			err_fin = ERR_FINAL_DEPTH;
		end
	end

	bre_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	// sticky error register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= ERR_NONE;
		end else if (accept) begin
			sticky_q <= tok.last ? ERR_NONE : err_cur;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && tok.last) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept && tok.last) begin
			result_bit_q <= (err_fin == ERR_NONE) ? stat.top_nxt : 1'b0;
			error_code_q <= err_fin;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.result_bit = result_bit_q;
	assign res.error_code = error_code_q;

	// held error survives tokens until the expression ends
	a_sticky_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !tok.last && sticky_q != ERR_NONE |=> sticky_q == $past(sticky_q))
		else $error("sticky error changed mid-expression");

	// depth stays within the stack
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.depth <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	// the stack is empty after the last token
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tok.last |=> stat.depth == '0 && sticky_q == ERR_NONE)
		else $error("stack not cleared after last token");

	// an error result carries a zero bit
	a_err_zero_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && error_code_q != ERR_NONE |-> !result_bit_q)
		else $error("result bit set with error");

	// a pending result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |=> out_valid_q && $stable(error_code_q)
			&& $stable(result_bit_q))
		else $error("pending result lost");

endmodule
